// ===== design/fted_pkg.sv =====
`timescale 1ns / 1ps

package fted_pkg;

  localparam int ADC_W      = 10;
  localparam int CIDX_W     = 5;
  localparam int COEF_W     = 16;
  localparam int SAMP_W     = 10;
  localparam int PROD_W     = 27;
  localparam int FRAC_W     = 15;
  localparam int Y_W        = 16;
  localparam int EN_W       = 31;
  localparam int VT_W       = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [ADC_W:0] ADC_MID = 11'sd512;

  localparam logic [EN_W-1:0] ENERGY_THR_RESET = 31'd2888640;
  localparam logic [VT_W-1:0] VOTE_THR_RESET   = 7'd70;

  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOTE_THR   = 4'd1;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_LOAD   = 1'b1
  } action_e;

  // Filter result handed from the MAC sequencer to the vote stage.
  typedef struct packed {
    logic                  valid;
    logic signed [Y_W-1:0] y;
  } fir_res_t;

endpackage

// ===== design/fted_if.sv =====
`timescale 1ns / 1ps

interface fted_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [fted_pkg::ADC_W-1:0]          adc_code;
  logic [fted_pkg::CIDX_W-1:0]         coef_index;
  logic signed [fted_pkg::COEF_W-1:0]  coef_value;

  modport source (output valid, action, adc_code, coef_index, coef_value, input ready);
  modport sink   (input valid, action, adc_code, coef_index, coef_value, output ready);
endinterface

interface fted_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fted_pkg::Y_W-1:0]    filtered;
  logic [fted_pkg::EN_W-1:0]          energy;
  logic                               above_threshold;
  logic [fted_pkg::VT_W-1:0]          vote_count;
  logic                               detected;
  logic                               detect_rose;
  logic                               detect_fell;

  modport source (output valid, filtered, energy, above_threshold, vote_count, detected,
                  detect_rose, detect_fell, input ready);
  modport sink   (input valid, filtered, energy, above_threshold, vote_count, detected,
                  detect_rose, detect_fell, output ready);
endinterface

interface fted_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fted_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [fted_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== design/fted_ram.sv =====
`timescale 1ns / 1ps

module fted_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read of the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fted_fir.sv =====
`timescale 1ns / 1ps

module fted_fir #(
  parameter int TAPS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fted_in_if.sink            in_ch,
  output fted_pkg::fir_res_t res_o,
  input  logic               res_ready_i
);

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW    = $clog2(TAPS + 1);
  localparam int ACC_W = fted_pkg::PROD_W + CW;
  localparam int Y_W   = fted_pkg::Y_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCALE,
    ST_HOLD
  } state_e;

  state_e                             state_q;
  logic [AW-1:0]                      wp_q;
  logic                               full_q;
  logic [TAPS-1:0]                    cvld_q;
  logic [CW-1:0]                      cnt_q;
  logic [AW-1:0]                      ridx_q;
  logic                               s1_q;
  logic                               s1_cv_q;
  logic                               s1_sv_q;
  logic                               s2_q;
  logic                               res_vld_q;
  logic signed [fted_pkg::PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]            acc_q;
  logic signed [Y_W-1:0]              y_q;

  logic                               accept;
  logic                               is_load;
  logic                               load_ok;
  logic [AW-1:0]                      coef_addr;
  logic [AW-1:0]                      cnt_idx;
  logic [fted_pkg::ADC_W:0]           centered;
  logic [fted_pkg::COEF_W-1:0]        coef_rd;
  logic [fted_pkg::SAMP_W-1:0]        samp_rd;
  logic signed [fted_pkg::COEF_W-1:0] coef_m;
  logic signed [fted_pkg::SAMP_W-1:0] samp_m;
  logic signed [ACC_W-1:0]            shifted;
  logic [ACC_W-Y_W:0]                 hi_bits;
  logic signed [Y_W-1:0]              y_sat;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign accept      = in_ch.valid && (state_q == ST_IDLE);
  assign is_load     = (in_ch.action == fted_pkg::ACT_LOAD);
  assign load_ok     = (32'(in_ch.coef_index) < 32'(TAPS));
  assign coef_addr   = AW'(in_ch.coef_index);
  assign cnt_idx     = AW'(cnt_q);
  assign centered    = $signed({1'b0, in_ch.adc_code}) - fted_pkg::ADC_MID;

  fted_ram #(
    .WIDTH (fted_pkg::COEF_W),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_load && load_ok),
    .waddr_i (coef_addr),
    .wdata_i (in_ch.coef_value),
    .raddr_i (cnt_idx),
    .rdata_o (coef_rd)
  );

  fted_ram #(
    .WIDTH (fted_pkg::SAMP_W),
    .DEPTH (TAPS)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (accept && !is_load),
    .waddr_i (wp_q),
    .wdata_i (centered[fted_pkg::SAMP_W-1:0]),
    .raddr_i (ridx_q),
    .rdata_o (samp_rd)
  );

  // Entries never written since reset read as zero.
  assign coef_m = s1_cv_q ? $signed(coef_rd) : '0;
  assign samp_m = s1_sv_q ? $signed(samp_rd) : '0;

  // Floor shift, then saturate when the bits above the result are not all sign copies.
  assign shifted = acc_q >>> fted_pkg::FRAC_W;
  assign hi_bits = shifted[ACC_W-1:Y_W-1];

  always_comb begin
    y_sat = shifted[Y_W-1:0];
    if (!(&hi_bits) && (|hi_bits)) begin
      y_sat = shifted[ACC_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      full_q    <= 1'b0;
      cvld_q    <= '0;
      cnt_q     <= '0;
      ridx_q    <= '0;
      s1_q      <= 1'b0;
      s1_cv_q   <= 1'b0;
      s1_sv_q   <= 1'b0;
      s2_q      <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      s1_q <= (state_q == ST_MAC) && (cnt_q != CW'(TAPS));
      s2_q <= s1_q;
      unique case (state_q)
        ST_IDLE: begin
          if (in_ch.valid) begin
            if (is_load) begin
              if (load_ok) begin
                cvld_q[coef_addr] <= 1'b1;
              end
            end else begin
              state_q <= ST_MAC;
              cnt_q   <= '0;
              ridx_q  <= wp_q;
            end
          end
        end
        ST_MAC: begin
          if (cnt_q != CW'(TAPS)) begin
            s1_cv_q <= cvld_q[cnt_idx];
            s1_sv_q <= full_q || (cnt_q <= CW'(wp_q));
            cnt_q   <= cnt_q + 1'b1;
            ridx_q  <= (ridx_q == '0) ? AW'(TAPS - 1) : ridx_q - 1'b1;
          end else if (!s1_q && !s2_q) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state_q   <= ST_HOLD;
          res_vld_q <= 1'b1;
          if (wp_q == AW'(TAPS - 1)) begin
            wp_q   <= '0;
            full_q <= 1'b1;
          end else begin
            wp_q <= wp_q + 1'b1;
          end
        end
        ST_HOLD: begin
          if (res_ready_i) begin
            res_vld_q <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      prod_q <= coef_m * samp_m;
    end
    if (accept && !is_load) begin
      acc_q <= '0;
    end else if (s2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (state_q == ST_SCALE) begin
      y_q <= y_sat;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.y     = y_q;

endmodule

// ===== design/fted_vote.sv =====
`timescale 1ns / 1ps

module fted_vote #(
  parameter int WINDOW = 100
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fted_pkg::fir_res_t           res_i,
  output logic                         res_ready_o,
  input  logic [fted_pkg::EN_W-1:0]    energy_thr_i,
  input  logic [fted_pkg::VT_W-1:0]    vote_thr_i,
  fted_out_if.source                   out_ch
);

  localparam int VW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TW   = $clog2(WINDOW + 1);
  localparam int CMPW = (TW > fted_pkg::VT_W) ? TW : fted_pkg::VT_W;
  localparam int Y_W  = fted_pkg::Y_W;
  localparam int EN_W = fted_pkg::EN_W;

  typedef enum logic [1:0] {
    V_IDLE,
    V_SQ,
    V_EMIT
  } state_e;

  state_e                  state_q;
  logic [VW-1:0]           vp_q;
  logic                    full_q;
  logic [TW-1:0]           total_q;
  logic                    prev_q;
  logic                    out_vld_q;
  logic signed [Y_W-1:0]   y_q;
  logic [EN_W-1:0]         energy_q;
  logic                    old_q;
  logic signed [Y_W-1:0]   filtered_q;
  logic [EN_W-1:0]         out_energy_q;
  logic                    above_q;
  logic [fted_pkg::VT_W-1:0] count_q;
  logic                    det_q;
  logic                    rose_q;
  logic                    fell_q;

  logic                    emit;
  logic                    pass;
  logic [TW-1:0]           total_d;
  logic                    det;
  logic signed [2*Y_W-1:0] sq;
  logic [0:0]              vote_rd;

  assign res_ready_o = (state_q == V_IDLE);
  assign emit        = (state_q == V_EMIT) && (!out_vld_q || out_ch.ready);
  assign sq          = y_q * y_q;
  assign pass        = (energy_q > energy_thr_i);
  assign total_d     = total_q - TW'(old_q) + TW'(pass);
  assign det         = (CMPW'(total_d) > CMPW'(vote_thr_i));

  // The window fills in pointer order, so the slot under the pointer holds a
  // written bit only once the pointer has wrapped.
  fted_ram #(
    .WIDTH (1),
    .DEPTH (WINDOW)
  ) u_vote_ram (
    .clk_i   (clk_i),
    .we_i    (emit),
    .waddr_i (vp_q),
    .wdata_i (pass),
    .raddr_i (vp_q),
    .rdata_o (vote_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= V_IDLE;
      vp_q      <= '0;
      full_q    <= 1'b0;
      total_q   <= '0;
      prev_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        V_IDLE: begin
          if (res_i.valid) begin
            state_q <= V_SQ;
          end
        end
        V_SQ: state_q <= V_EMIT;
        V_EMIT: begin
          if (emit) begin
            state_q   <= V_IDLE;
            total_q   <= total_d;
            prev_q    <= det;
            if (vp_q == VW'(WINDOW - 1)) begin
              vp_q   <= '0;
              full_q <= 1'b1;
            end else begin
              vp_q <= vp_q + 1'b1;
            end
          end
        end
        default: state_q <= V_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == V_IDLE && res_i.valid) begin
      y_q <= res_i.y;
    end
    if (state_q == V_SQ) begin
      energy_q <= sq[EN_W-1:0];
      old_q    <= vote_rd[0] && full_q;
    end
    if (emit) begin
      filtered_q   <= y_q;
      out_energy_q <= energy_q;
      above_q      <= pass;
      count_q      <= fted_pkg::VT_W'(total_d);
      det_q        <= det;
      rose_q       <= det && !prev_q;
      fell_q       <= !det && prev_q;
    end
  end

  assign out_ch.valid           = out_vld_q;
  assign out_ch.filtered        = filtered_q;
  assign out_ch.energy          = out_energy_q;
  assign out_ch.above_threshold = above_q;
  assign out_ch.vote_count      = count_q;
  assign out_ch.detected        = det_q;
  assign out_ch.detect_rose     = rose_q;
  assign out_ch.detect_fell     = fell_q;

endmodule

// ===== design/fir_tone_energy_detector.sv =====
`timescale 1ns / 1ps

// Tone detector: a TAPS-tap FIR filter over centered converter codes, the
// square of its output against an energy threshold, and a vote over the last
// WINDOW pass bits.
// in_ch carries one request per item: a load request (action high) writes one
// Q1.15 coefficient and yields no result; a sample request
// produces exactly one result on out_ch. cfg_ch writes the energy threshold
// (index 0) or the vote threshold (index 1) and is always ready; write it
// only while no sample is in flight.
// A sample runs one multiply-accumulate per tap through the coefficient and
// sample memories, one tap per cycle; in_ch takes no new request until the
// vote stage has taken the sample's result.
// A finished result waits in an output register while the next sample is
// already filtered; if the receiver stalls longer, the filter holds its result
// and in_ch stays low until a slot opens.
// Reset clears the thresholds to their defaults, and all coefficients, delay
// samples and vote bits read as zero until written; no clearing pass is needed.

module fir_tone_energy_detector #(
  parameter int TAPS   = 32,
  parameter int WINDOW = 100
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fted_in_if.sink    in_ch,
  fted_out_if.source out_ch,
  fted_cfg_if.sink   cfg_ch
);

  logic [fted_pkg::EN_W-1:0] energy_thr_q;
  logic [fted_pkg::VT_W-1:0] vote_thr_q;
  fted_pkg::fir_res_t        fir_res;
  logic                      fir_res_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_thr_q <= fted_pkg::ENERGY_THR_RESET;
      vote_thr_q   <= fted_pkg::VOTE_THR_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        fted_pkg::REG_ENERGY_THR: energy_thr_q <= cfg_ch.wdata[fted_pkg::EN_W-1:0];
        fted_pkg::REG_VOTE_THR:   vote_thr_q   <= cfg_ch.wdata[fted_pkg::VT_W-1:0];
        default: ;
      endcase
    end
  end

  fted_fir #(
    .TAPS (TAPS)
  ) u_fir (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .res_o       (fir_res),
    .res_ready_i (fir_res_ready)
  );

  fted_vote #(
    .WINDOW (WINDOW)
  ) u_vote (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (fir_res),
    .res_ready_o  (fir_res_ready),
    .energy_thr_i (energy_thr_q),
    .vote_thr_i   (vote_thr_q),
    .out_ch       (out_ch)
  );

endmodule

// ===== design/fted_chk.sv =====
`timescale 1ns / 1ps

module fted_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              in_action_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [fted_pkg::Y_W-1:0]   filtered_i,
  input logic [fted_pkg::EN_W-1:0]         energy_i,
  input logic                              detected_i,
  input logic                              detect_rose_i,
  input logic                              detect_fell_i
);

  logic signed [2*fted_pkg::Y_W-1:0] filt_wide;
  logic signed [2*fted_pkg::Y_W-1:0] filt_sq;

  assign filt_wide = (2*fted_pkg::Y_W)'(filtered_i);
  assign filt_sq   = filt_wide * filt_wide;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(filtered_i) && $stable(energy_i))
    else $error("result changed while stalled");

  a_energy_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (filt_sq == (2*fted_pkg::Y_W)'(energy_i)))
    else $error("energy is not the square of the filter output");

  a_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!detect_rose_i || detected_i) && (!detect_fell_i || !detected_i))
    else $error("edge flag disagrees with detection");

  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == fted_pkg::ACT_SAMPLE) |=> !in_ready_i)
    else $error("input ready right after a sample request");

endmodule

bind fir_tone_energy_detector fted_chk u_fted_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .in_action_i   (in_ch.action),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .filtered_i    (out_ch.filtered),
  .energy_i      (out_ch.energy),
  .detected_i    (out_ch.detected),
  .detect_rose_i (out_ch.detect_rose),
  .detect_fell_i (out_ch.detect_fell)
);

// ===== sim/tone_detect_checker.sv =====
`timescale 1ns / 1ps

module tone_detect_checker
  import fted_pkg::*;
#(
  parameter int TAPS   = 32,
  parameter int WINDOW = 100
) (
  input  logic clk_i,
  input  logic rst_ni,
  fted_in_if   in_ch,
  fted_out_if  out_ch,
  fted_cfg_if  cfg_ch,
  output int   mismatch_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    logic signed [Y_W-1:0] filtered;
    logic [EN_W-1:0]       energy;
    logic                  above;
    logic [VT_W-1:0]       votes;
    logic                  det;
    logic                  rose;
    logic                  fell;
  } tone_result_t;

  tone_result_t             tone_results_q[$];
  logic signed [ADC_W:0]    delay_line [TAPS];
  logic signed [COEF_W-1:0] coef_mem [TAPS];
  logic                     vote_bits [WINDOW];
  int                       line_wr;
  int                       vote_wr;
  int                       vote_sum;
  logic                     was_detected;
  logic [EN_W-1:0]          energy_thr;
  logic [VT_W-1:0]          vote_thr;
  int                       mismatches = 0;

  // Runs one sample through the filter, the energy test and the vote window.
  function automatic tone_result_t filter_and_vote(input logic [ADC_W-1:0] code);
    tone_result_t r;
    longint       acc;
    longint       y;
    longint       pwr;
    int           rd;
    logic         hit;
    logic         det;
    acc = 0;
    delay_line[line_wr] = $signed({1'b0, code}) - ADC_MID;
    rd = line_wr;
    for (int k = 0; k < TAPS; k++) begin
      acc += longint'(coef_mem[k]) * longint'(delay_line[rd]);
      rd = (rd == 0) ? TAPS - 1 : rd - 1;
    end
    line_wr = (line_wr == TAPS - 1) ? 0 : line_wr + 1;

    // Arithmetic shift rounds toward minus infinity, as the hardware does.
    y = acc >>> FRAC_W;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    pwr = y * y;
    hit = (pwr > longint'(energy_thr));

    vote_sum = vote_sum - int'(vote_bits[vote_wr]) + int'(hit);
    vote_bits[vote_wr] = hit;
    vote_wr = (vote_wr == WINDOW - 1) ? 0 : vote_wr + 1;
    det = (vote_sum > int'(vote_thr));

    r.filtered   = y[Y_W-1:0];
    r.energy     = pwr[EN_W-1:0];
    r.above      = hit;
    r.votes      = vote_sum[VT_W-1:0];
    r.det        = det;
    r.rose       = det && !was_detected;
    r.fell       = !det && was_detected;
    was_detected = det;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tone_result_t head;
    if (!rst_ni) begin
      tone_results_q.delete();
      for (int k = 0; k < TAPS; k++) begin
        delay_line[k] = '0;
        coef_mem[k]   = '0;
      end
      for (int k = 0; k < WINDOW; k++) vote_bits[k] = 1'b0;
      line_wr      = 0;
      vote_wr      = 0;
      vote_sum     = 0;
      was_detected = 1'b0;
      energy_thr   = ENERGY_THR_RESET;
      vote_thr     = VOTE_THR_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (tone_results_q.size() == 0) begin
          $display("%0t: result request with no expected result, filtered %0d", $time,
                   out_ch.filtered);
          mismatches++;
        end else begin
          head = tone_results_q.pop_front();
          compare_field("filtered", head.filtered, out_ch.filtered);
          compare_field("energy", {1'b0, head.energy}, {1'b0, out_ch.energy});
          compare_field("above_threshold", {1'b0, head.above}, {1'b0, out_ch.above_threshold});
          compare_field("vote_count", {1'b0, head.votes}, {1'b0, out_ch.vote_count});
          compare_field("detected", {1'b0, head.det}, {1'b0, out_ch.detected});
          compare_field("detect_rose", {1'b0, head.rose}, {1'b0, out_ch.detect_rose});
          compare_field("detect_fell", {1'b0, head.fell}, {1'b0, out_ch.detect_fell});
        end
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_ENERGY_THR: energy_thr = cfg_ch.wdata[EN_W-1:0];
          REG_VOTE_THR:   vote_thr   = cfg_ch.wdata[VT_W-1:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_LOAD) begin
          if (int'(in_ch.coef_index) < TAPS) coef_mem[in_ch.coef_index] = in_ch.coef_value;
        end else begin
          tone_results_q.push_back(filter_and_vote(in_ch.adc_code));
        end
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= tone_results_q.size();
  end

endmodule

// ===== sim/fir_tone_energy_detector_tb.sv =====
`timescale 1ns / 1ps

module fir_tone_energy_detector_tb;
  import fted_pkg::*;

  localparam int TAPS          = 32;
  localparam int WINDOW        = 100;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = TAPS + 16;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 115;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic calm   = 1'b0;
  int   cycle_cnt  = 0;
  int   stall_left = 0;
  int   n_errors;
  int   n_pending;

  fted_in_if  in_ch ();
  fted_out_if out_ch ();
  fted_cfg_if cfg_ch ();

  fir_tone_energy_detector #(
    .TAPS   (TAPS),
    .WINDOW (WINDOW)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tone_detect_checker #(
    .TAPS   (TAPS),
    .WINDOW (WINDOW)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_cnt_o (n_errors),
    .pending_o      (n_pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  always @(posedge clk_i) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Returns at the edge where the request was taken; valid stays high so a
  // following request can go out back to back.
  task automatic send_item(input action_e act, input logic [ADC_W-1:0] code,
                           input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.adc_code   <= code;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= val;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic put_sample(input logic [ADC_W-1:0] code);
    send_item(ACT_SAMPLE, code, CIDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic load_coef(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    send_item(ACT_LOAD, ADC_W'($urandom), idx, val);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops the stimulus and waits until every result is in and the filter is idle.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    bit loud;
    int burst_left;
    int n_loads;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_SAMPLE;
    in_ch.adc_code   <= '0;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= '0;
    cfg_ch.wdata     <= '0;
    loud       = 1'b0;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With all coefficients zero every output is zero.
    put_sample(10'd512);
    put_sample(10'd0);
    put_sample(10'd1023);
    // Single tap at both ends of the coefficient range, full-scale codes.
    load_coef(5'd0, 16'sh7fff);
    put_sample(10'd1023);
    put_sample(10'd0);
    load_coef(5'd0, 16'sh8000);
    put_sample(10'd0);
    put_sample(10'd1023);
    // Last tap written twice, then alternating bit patterns in the middle.
    load_coef(5'd31, 16'sh8000);
    load_coef(5'd31, 16'sh7fff);
    load_coef(5'd15, 16'sh5555);
    load_coef(5'd16, 16'shaaaa);
    put_sample(10'd0);
    put_sample(10'd1023);
    quiesce();
    // Lowest thresholds: any nonzero output passes and one vote detects.
    write_reg(REG_ENERGY_THR, 32'd0);
    write_reg(REG_VOTE_THR, 32'd0);
    put_sample(10'd1023);
    put_sample(10'd512);
    put_sample(10'd0);
    repeat (3) put_sample(10'd512);

    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      case (ph)
        0: begin
          write_reg(REG_ENERGY_THR, 32'd10000);
          write_reg(REG_VOTE_THR, 32'd40);
        end
        1: begin
          write_reg(REG_ENERGY_THR, 32'h4000_0000);
          write_reg(REG_VOTE_THR, 32'd100);
        end
        2: begin
          write_reg(REG_SPARE_LO, $urandom);
          write_reg(REG_SPARE_HI, $urandom);
          write_reg(REG_ENERGY_THR, 32'hffff_ffff);
          write_reg(REG_VOTE_THR, 32'hffff_ffff);
        end
        3: begin
          write_reg(REG_ENERGY_THR, 32'd0);
          write_reg(REG_VOTE_THR, $urandom_range(0, 100));
        end
        default: begin
          write_reg(REG_ENERGY_THR, $urandom_range(0, 200000));
          write_reg(REG_VOTE_THR, $urandom_range(20, 100));
        end
      endcase

      // The first phase loads a full random coefficient set; later ones
      // change a few taps.
      n_loads = (ph == 0) ? TAPS : $urandom_range(0, 8);
      for (int k = 0; k < n_loads; k++)
        load_coef((ph == 0) ? k[CIDX_W-1:0] : CIDX_W'($urandom_range(0, TAPS - 1)),
                  COEF_W'($urandom));

      // Loud and quiet bursts make the vote cross its threshold both ways.
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          loud       = !loud;
          burst_left = $urandom_range(20, 110);
          calm       <= ($urandom_range(0, 3) == 0);
        end
        burst_left--;
        if ($urandom_range(0, 19) == 0)
          load_coef(CIDX_W'($urandom), COEF_W'($urandom));
        else if (loud)
          put_sample(ADC_W'($urandom_range(0, 1023)));
        else
          put_sample(ADC_W'(512 + $urandom_range(0, 6) - 3));
      end
    end

    quiesce();
    if (n_errors == 0 && n_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
